/* sv/ple_pkg.sv */
// Shared codes, widths and the request decision type of the positional list engine.
package ple_pkg;

  // Field widths
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int TOTAL_W = 7;
  localparam int ST_W    = 2;
  localparam int DATA_W  = 40;
  localparam int OP_W    = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_COUNT     = 3'd7;

  // Result status
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  // Work the sequencer has to carry out
  localparam logic [OP_W-1:0] OP_NONE = 2'd0;
  localparam logic [OP_W-1:0] OP_INS  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_DUMP = 2'd3;

  // Decision for one request
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] idx;      // 0-based slot of the edit
    logic             no_move;  // edit at the tail end, nothing to shift
  } ple_dec_t;

endpackage

/* sv/positional_list_engine.sv */
// Top level: list store sequencer, shift engine over one RAM port pair, result register.
// Count and refused requests: one beat, loaded from the finish state into the result register.
// Insert/delete at slot k: one shift step per moved element (count-k for insert, count-k-1
// for delete) through the store's read/write port pair, then flush and finish; tail edits skip the shift.
// Dump: one beat per element each cycle after a read start on accept, stalled by m_tready.
// Reset (rst, synchronous) empties the list and idles the sequencer; the store keeps data.
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
  input  logic [2:0]  s_tuser,   // [2:0] kind
  // result beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] entry_value, [38:32] element_total, [39] zero
  output logic [2:0]  m_tuser,   // [0] entry_valid, [2:1] status
  output logic        m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_FLUSH  = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_DUMP   = 3'd4;

  logic [2:0]                     state, state_next;
  logic [ple_pkg::OP_W-1:0]       op;
  logic [ple_pkg::ST_W-1:0]       status;
  logic [AW-1:0]                  idx;
  logic [AW-1:0]                  last_idx;
  logic [AW-1:0]                  ptr;
  logic [ple_pkg::VALUE_W-1:0]    value_r;
  logic                           pend;
  logic [AW-1:0]                  pend_addr;
  logic [CW-1:0]                  count, count_next;

  logic                           s_beat;
  logic                           out_free;
  logic                           shift_end;
  logic                           dump_last;
  ple_pkg::ple_dec_t              dec;

  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [ple_pkg::VALUE_W-1:0]    wr_data;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic [ple_pkg::VALUE_W-1:0]    rd_data;

  logic                           load;
  logic [ple_pkg::VALUE_W-1:0]    o_value;
  logic                           o_valid;
  logic                           o_last;
  logic [ple_pkg::ST_W-1:0]       o_status;
  logic [ple_pkg::VALUE_W-1:0]    r_value;
  logic                           r_valid;
  logic                           r_last;
  logic [ple_pkg::TOTAL_W-1:0]    r_total;
  logic [ple_pkg::ST_W-1:0]       r_status;

  assign s_tready = (state == S_IDLE);
  assign s_beat   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  ple_dec #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_dec (
    .kind     (s_tuser),
    .position (s_tdata[38:32]),
    .count    (count),
    .dec      (dec)
  );

  ple_ram #(
    .WIDTH (ple_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign shift_end = (op == ple_pkg::OP_INS) ? (ptr == idx) : (ptr == last_idx);
  assign dump_last = (ptr == last_idx);

  // Store read: shift source, dump start and dump prefetch
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr;
    if (s_beat && dec.op == ple_pkg::OP_DUMP) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (state == S_SHIFT) begin
      rd_en = 1'b1;
    end else if (state == S_DUMP && out_free && !dump_last) begin
      rd_en   = 1'b1;
      rd_addr = ptr + AW'(1);
    end
  end

  // Store write: moved element, or the new value when the insert finishes
  always_comb begin
    wr_en   = pend || (state == S_FINISH && out_free && op == ple_pkg::OP_INS);
    wr_addr = pend ? pend_addr : idx;
    wr_data = pend ? rd_data : value_r;
  end

  // Count after the request
  always_comb begin
    count_next = count;
    if (state == S_FINISH && out_free) begin
      unique case (op)
        ple_pkg::OP_INS: count_next = count + CW'(1);
        ple_pkg::OP_DEL: count_next = count - CW'(1);
        default:         count_next = count;
      endcase
    end
  end

  // Result beat content
  always_comb begin
    load     = 1'b0;
    o_value  = '0;
    o_valid  = 1'b0;
    o_last   = 1'b1;
    o_status = status;
    if (state == S_FINISH && out_free) begin
      load = 1'b1;
    end else if (state == S_DUMP && out_free) begin
      load     = 1'b1;
      o_value  = rd_data;
      o_valid  = 1'b1;
      o_last   = dump_last;
      o_status = ple_pkg::ST_DONE;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_beat) begin
          if (dec.op == ple_pkg::OP_DUMP) begin
            state_next = S_DUMP;
          end else if (dec.op == ple_pkg::OP_NONE || dec.no_move) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT:  if (shift_end) state_next = S_FLUSH;
      S_FLUSH:  state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      S_DUMP:   if (out_free && dump_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= (state == S_SHIFT);
    end
  end

  // Request registers and shift pointer
  always_ff @(posedge clk) begin
    if (s_beat) begin
      op       <= dec.op;
      status   <= dec.status;
      idx      <= AW'(dec.idx);
      value_r  <= s_tdata[31:0];
      last_idx <= AW'(count - CW'(1));
      unique case (dec.op)
        ple_pkg::OP_INS: ptr <= AW'(count - CW'(1));
        ple_pkg::OP_DEL: ptr <= AW'(dec.idx) + AW'(1);
        default:         ptr <= '0;
      endcase
    end else if (state == S_SHIFT) begin
      pend_addr <= (op == ple_pkg::OP_INS) ? ptr + AW'(1) : ptr - AW'(1);
      if (!shift_end) begin
        ptr <= (op == ple_pkg::OP_INS) ? ptr - AW'(1) : ptr + AW'(1);
      end
    end else if (state == S_DUMP && out_free && !dump_last) begin
      ptr <= ptr + AW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r_value  <= o_value;
      r_valid  <= o_valid;
      r_last   <= o_last;
      r_total  <= ple_pkg::TOTAL_W'(count_next);
      r_status <= o_status;
    end
  end

  assign m_tdata = {1'b0, r_total, r_value};
  assign m_tuser = {r_status, r_valid};
  assign m_tlast = r_last;

`ifndef SYNTH
  // List never grows past its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  // Count moves by at most one per request
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                     count == $past(count) - CW'(1)))
    else $error("element count jumped");

  // Pending moves exist only right after a shift read
  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SHIFT || state == S_FLUSH))
    else $error("store move outside shift");

  // Full refusal reports a full list
  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] == ple_pkg::ST_FULL) |-> (m_tdata[38:32] == 7'(CAPACITY)))
    else $error("full status with list not full");

  // Element beats of a dump carry done status
  a_dump_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == ple_pkg::ST_DONE))
    else $error("dump beat with error status");
`endif

endmodule

/* sv/ple_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/ple_dec.sv */
// Request decoder: range, full and empty checks and the edit slot.
module ple_dec #(
  parameter int CAPACITY = 64,
  parameter int CW       = 7
) (
  input  logic [ple_pkg::KIND_W-1:0] kind,
  input  logic [ple_pkg::POS_W-1:0]  position,
  input  logic [CW-1:0]              count,
  output ple_pkg::ple_dec_t          dec
);

  logic [7:0] cnt8;
  logic [7:0] pos8;
  logic [7:0] ins_p;
  logic [7:0] del_p;
  logic       is_ins;
  logic       is_del;

  assign cnt8 = 8'(count);
  assign pos8 = 8'(position);

  assign is_ins = (kind == ple_pkg::KIND_INS_FRONT) || (kind == ple_pkg::KIND_INS_BACK) ||
                  (kind == ple_pkg::KIND_INS_AT);
  assign is_del = (kind == ple_pkg::KIND_DEL_FRONT) || (kind == ple_pkg::KIND_DEL_BACK) ||
                  (kind == ple_pkg::KIND_DEL_AT);

  // 1-based target position per kind
  always_comb begin
    unique case (kind)
      ple_pkg::KIND_INS_BACK: ins_p = cnt8 + 8'd1;
      ple_pkg::KIND_INS_AT:   ins_p = pos8;
      default:                ins_p = 8'd1;
    endcase
    unique case (kind)
      ple_pkg::KIND_DEL_BACK: del_p = cnt8;
      ple_pkg::KIND_DEL_AT:   del_p = pos8;
      default:                del_p = 8'd1;
    endcase
  end

  // Checks in order: range before full, empty before range
  always_comb begin
    dec.op      = ple_pkg::OP_NONE;
    dec.status  = ple_pkg::ST_DONE;
    dec.idx     = '0;
    dec.no_move = 1'b0;
    if (is_ins) begin
      if (ins_p == 8'd0 || ins_p > cnt8 + 8'd1) begin
        dec.status = ple_pkg::ST_RANGE;
      end else if (cnt8 >= 8'(CAPACITY)) begin
        dec.status = ple_pkg::ST_FULL;
      end else begin
        dec.op      = ple_pkg::OP_INS;
        dec.idx     = 7'(ins_p - 8'd1);
        dec.no_move = (ins_p == cnt8 + 8'd1);
      end
    end else if (is_del) begin
      if (cnt8 == 8'd0) begin
        dec.status = ple_pkg::ST_EMPTY;
      end else if (del_p == 8'd0 || del_p > cnt8) begin
        dec.status = ple_pkg::ST_RANGE;
      end else begin
        dec.op      = ple_pkg::OP_DEL;
        dec.idx     = 7'(del_p - 8'd1);
        dec.no_move = (del_p == cnt8);
      end
    end else if (kind == ple_pkg::KIND_DUMP && cnt8 != 8'd0) begin
      dec.op = ple_pkg::OP_DUMP;
    end
  end

endmodule
